[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LRUPR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define LRUPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define LRUPR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LRUPR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/core/lrupr_pkg.sv]
// ---------------------------------------------------------------------------
// LRU page replacement package
// Port widths and parameter defaults shared by the replacement unit.
// ---------------------------------------------------------------------------
`default_nettype none
package lrupr_pkg;
   localparam int PAGE_PORT_W    = 16;
   localparam int FRAME_INDEX_W  = 2;
   localparam int FAULT_COUNT_W  = 32;
   localparam int NUM_FRAMES_DEF = 4;
   localparam int PAGE_BITS_DEF  = 16;
endpackage
`default_nettype wire

[rtl/core/lrupr_select.sv]
// ---------------------------------------------------------------------------
// LRU frame selection
// Associative page lookup and victim choice over all frames in one pass.
// ---------------------------------------------------------------------------
`default_nettype none
module lrupr_select #(
   parameter int NUM_FRAMES = lrupr_pkg::NUM_FRAMES_DEF,
   parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF,
   localparam int IdxW      = $clog2(NUM_FRAMES)
)(
   input  wire logic [NUM_FRAMES-1:0][PAGE_BITS-1:0] frame_page,
   input  wire logic [NUM_FRAMES-1:0]                frame_valid,
   input  wire logic [NUM_FRAMES-1:0][IdxW-1:0]      recency_rank,
   input  wire logic [PAGE_BITS-1:0]                 page,
   output logic                                      hit,
   output logic                                      fill_invalid,
   output logic [IdxW-1:0]                           sel_idx,
   output logic [NUM_FRAMES-1:0]                     rank_max_vec
);
   localparam logic [IdxW-1:0] RankMax = IdxW'(NUM_FRAMES - 1);

   logic [IdxW-1:0] hit_idx;
   logic [IdxW-1:0] inv_idx;
   logic [IdxW-1:0] lru_idx;
   logic            any_invalid;

   // Walking downward leaves the lowest-numbered candidate in each encoder.
   always_comb begin
      hit          = 1'b0;
      hit_idx      = '0;
      any_invalid  = 1'b0;
      inv_idx      = '0;
      lru_idx      = '0;
      rank_max_vec = '0;
      for (int j = NUM_FRAMES - 1; j >= 0; j--) begin
         rank_max_vec[j] = (recency_rank[j] == RankMax);
         if (frame_valid[j] && (frame_page[j] == page)) begin
            hit     = 1'b1;
            hit_idx = IdxW'(j);
         end
         if (!frame_valid[j]) begin
            any_invalid = 1'b1;
            inv_idx     = IdxW'(j);
         end
         // With every frame valid the ranks form a permutation, so the oldest
         // frame is the one that carries the largest rank.
         if (recency_rank[j] == RankMax) begin
            lru_idx = IdxW'(j);
         end
      end
   end

   always_comb begin
      fill_invalid = !hit && any_invalid;
      if (hit) begin
         sel_idx = hit_idx;
      end else if (any_invalid) begin
         sel_idx = inv_idx;
      end else begin
         sel_idx = lru_idx;
      end
   end
endmodule
`default_nettype wire

[rtl/core/lru_page_replacement.sv]
// ---------------------------------------------------------------------------
// LRU page replacement unit
// Fully associative frame set with least-recently-used replacement.
// ---------------------------------------------------------------------------
// Usage:
//   Each req_ transaction carries one page reference; each rsp_ transaction
//   returns its result: hit or fault, the frame that now holds the page, the
//   evicted page if a valid one was replaced, and the saturating fault count.
//   A transaction moves at a clock edge with valid high and stall low.
//   The reference is captured in the input register, then looked up, the
//   frame state is updated and the result register is loaded once it is
//   free. One reference is taken every cycle while rsp_stall is low; the
//   limit is the combinational lookup and rank update against the frame registers.
//   When rsp_stall holds a result, the reference behind it waits in the
//   input register and req_stall rises only once that register is occupied.
//   Reset empties both registers, marks all frames invalid and clears the
//   fault count. A reference with last_in_run set does the same to the
//   frames and count after its own result is formed.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module lru_page_replacement #(
   parameter int NUM_FRAMES = lrupr_pkg::NUM_FRAMES_DEF,
   parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
)(
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [lrupr_pkg::PAGE_PORT_W-1:0]     req_page_number,
   input  wire logic                                  req_last_in_run,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_page_fault,
   output logic [lrupr_pkg::FRAME_INDEX_W-1:0]        rsp_frame_index,
   output logic                                       rsp_evicted_valid,
   output logic [lrupr_pkg::PAGE_PORT_W-1:0]          rsp_evicted_page,
   output logic [lrupr_pkg::FAULT_COUNT_W-1:0]        rsp_fault_count,
   output logic                                       rsp_run_done
);
   localparam int IdxW   = $clog2(NUM_FRAMES);
   localparam int PortW  = lrupr_pkg::PAGE_PORT_W;
   localparam int FrameW = lrupr_pkg::FRAME_INDEX_W;
   localparam int CountW = lrupr_pkg::FAULT_COUNT_W;

   // Input register
   logic                 in_valid_ff, in_valid_in;
   logic [PAGE_BITS-1:0] in_page_ff, in_page_in;
   logic                 in_last_ff, in_last_in;

   // Frame state
   logic [NUM_FRAMES-1:0][PAGE_BITS-1:0] frame_page_ff, frame_page_in;
   logic [NUM_FRAMES-1:0]                frame_valid_ff, frame_valid_in;
   logic [NUM_FRAMES-1:0][IdxW-1:0]      rank_ff, rank_in;
   logic [CountW-1:0]                    faults_ff, faults_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_fault_ff, rsp_fault_in;
   logic [FrameW-1:0] rsp_index_ff, rsp_index_in;
   logic              rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [PortW-1:0]  rsp_ev_page_ff, rsp_ev_page_in;
   logic [CountW-1:0] rsp_count_ff, rsp_count_in;
   logic              rsp_done_ff, rsp_done_in;

   logic              rsp_free;
   logic              process;
   logic              req_accept;
   logic              lk_hit;
   logic              lk_fill;
   logic              lk_evict;
   logic [IdxW-1:0]   lk_idx;
   logic [IdxW-1:0]   old_rank;
   logic [NUM_FRAMES-1:0] rank_max_vec;
   logic [CountW-1:0] faults_inc;

   lrupr_select #(
      .NUM_FRAMES (NUM_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_select (
      .frame_page   (frame_page_ff),
      .frame_valid  (frame_valid_ff),
      .recency_rank (rank_ff),
      .page         (in_page_ff),
      .hit          (lk_hit),
      .fill_invalid (lk_fill),
      .sel_idx      (lk_idx),
      .rank_max_vec (rank_max_vec)
   );

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign process    = in_valid_ff && rsp_free;
   assign req_stall  = in_valid_ff && !rsp_free;
   assign req_accept = req_valid && !req_stall;
   assign lk_evict   = !lk_hit && !lk_fill;
   assign old_rank   = rank_ff[lk_idx];
   assign faults_inc = (faults_ff == '1) ? faults_ff : faults_ff + CountW'(1);

   always_comb begin
      in_valid_in  = req_accept || (in_valid_ff && !process);
      in_page_in   = req_accept ? PAGE_BITS'(req_page_number) : in_page_ff;
      in_last_in   = req_accept ? req_last_in_run : in_last_ff;
      rsp_valid_in = process || (rsp_valid_ff && rsp_stall);
   end

   // Frame state update for the reference being resolved.
   always_comb begin
      frame_page_in  = frame_page_ff;
      frame_valid_in = frame_valid_ff;
      rank_in        = rank_ff;
      faults_in      = faults_ff;
      if (process) begin
         // Valid frames younger than the touched one age by one; on a fill from
         // invalid every other valid frame ages. The touched frame gets rank zero.
         for (int j = 0; j < NUM_FRAMES; j++) begin
            if ((IdxW'(j) != lk_idx) && frame_valid_ff[j] &&
                (lk_fill || (rank_ff[j] < old_rank))) begin
               rank_in[j] = rank_ff[j] + IdxW'(1);
            end
         end
         rank_in[lk_idx] = '0;
         if (!lk_hit) begin
            frame_page_in[lk_idx]  = in_page_ff;
            frame_valid_in[lk_idx] = 1'b1;
            faults_in              = faults_inc;
         end
         if (in_last_ff) begin
            frame_valid_in = '0;
            rank_in        = '0;
            faults_in      = '0;
         end
      end
   end

   always_comb begin
      rsp_fault_in    = rsp_fault_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_page_in  = rsp_ev_page_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_done_in     = rsp_done_ff;
      if (process) begin
         rsp_fault_in    = !lk_hit;
         rsp_index_in    = FrameW'(lk_idx);
         rsp_ev_valid_in = lk_evict;
         rsp_ev_page_in  = lk_evict ? PortW'(frame_page_ff[lk_idx]) : '0;
         rsp_count_in    = lk_hit ? faults_ff : faults_inc;
         rsp_done_in     = in_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         frame_valid_ff <= '0;
         rank_ff        <= '0;
         faults_ff      <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         frame_valid_ff <= frame_valid_in;
         rank_ff        <= rank_in;
         faults_ff      <= faults_in;
      end
   end

   always_ff @(posedge clock) begin
      in_page_ff      <= in_page_in;
      in_last_ff      <= in_last_in;
      frame_page_ff   <= frame_page_in;
      rsp_fault_ff    <= rsp_fault_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_done_ff     <= rsp_done_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_page_fault    = rsp_fault_ff;
   assign rsp_frame_index   = rsp_index_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_count   = rsp_count_ff;
   assign rsp_run_done      = rsp_done_ff;

   // A hit never replaces a page.
   `LRUPR_ASSERT_IMPL(a_hit_no_evict, clock, reset, rsp_valid_ff && !rsp_fault_ff, !rsp_ev_valid_ff)
   // With every frame valid exactly one frame is the oldest.
   `LRUPR_ASSERT_IMPL(a_single_lru, clock, reset, &frame_valid_ff, $onehot(rank_max_vec))
   // The last reference of a run leaves the frames and the count cleared.
   `LRUPR_ASSERT_NEXT(a_run_clear, clock, reset, process && in_last_ff, (frame_valid_ff == '0) && (faults_ff == '0))
endmodule
`default_nettype wire
